// ===== rtl/core/gad_pkg.sv =====
package gad_pkg;

	localparam int SAMPLE_WIDTH_DEF  = 16;
	localparam int FRACTION_BITS_DEF = 14;

	localparam int OUT_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int TDZ_W     = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_DZ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STICK_DZ   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd2;

	localparam logic [TDZ_W-1:0] TRIGGER_DZ_RST = 15'd250;
	localparam logic [CFG_W-1:0] STICK_DZ_RST   = 16'd8000;
	localparam logic [CFG_W-1:0] FULL_SCALE_RST = 16'd30000;

	typedef enum logic {
		OP_TRIGGER = 1'b0,
		OP_STICK   = 1'b1
	} op_t;

endpackage

// ===== rtl/core/gamepad_axis_dead_zone.sv =====
// Channel  Dir  Fields (lowest bit up)                   Accepted when
// s_*      in   tdata: axis_x, axis_y; tuser: operation  s_tvalid && s_tready
// m_*      out  tdata: out_x, out_y; tuser: in_dead_zone m_tvalid && m_tready
// cfg_*    in   index, data                              cfg_we high
//
// One word per cycle sustained unless m_tready stalls the output; one root bit
// per stage in the square root pipeline and one quotient bit per stage in the
// divider pipeline.
// Reset clears all stage valid bits and loads the register defaults.
// Every stage holds while its successor is full and fills bubbles otherwise.
module gamepad_axis_dead_zone
	import gad_pkg::*;
#(
	parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// axis_x, axis_y, zero pad
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
	// operation
	input  logic [0:0]                           s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// out_x, out_y
	output logic [2*OUT_W-1:0]                   m_tdata,
	// in_dead_zone
	output logic [0:0]                           m_tuser,
	input  logic                                 cfg_we,
	input  logic [CFG_IDX_W-1:0]                 cfg_index,
	input  logic [CFG_W-1:0]                     cfg_data
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int QW     = FRACTION_BITS + 1;
	localparam int CW     = (SW > CFG_W) ? SW : CFG_W;
	localparam int MW     = SW + CFG_W;
	localparam int PW     = (QW > OUT_W) ? QW : OUT_W;
	localparam int SIDE_W = 5 + 3 * SW;

	logic [TDZ_W-1:0] trig_dz_q;
	logic [CFG_W-1:0] stick_dz_q;
	logic [CFG_W-1:0] full_scale_q;
	logic [CFG_W-1:0] tdz16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_dz_q    <= TRIGGER_DZ_RST;
			stick_dz_q   <= STICK_DZ_RST;
			full_scale_q <= FULL_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRIGGER_DZ: trig_dz_q    <= cfg_data[TDZ_W-1:0];
				CFG_STICK_DZ:   stick_dz_q   <= cfg_data;
				CFG_FULL_SCALE: full_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign tdz16 = {1'b0, trig_dz_q};

	// s1: magnitudes and signs
	logic          v_s1, rdy_s1;
	op_t           op_s1;
	logic [SW-1:0] ax_s1, ay_s1;
	logic          negx_s1, negy_s1;
	logic [SW-1:0] in_x, in_y;

	assign in_x     = s_tdata[SW-1:0];
	assign in_y     = s_tdata[2*SW-1:SW];
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			op_s1   <= op_t'(s_tuser[0]);
			ax_s1   <= in_x[SW-1] ? (~in_x + 1'b1) : in_x;
			ay_s1   <= in_y[SW-1] ? (~in_y + 1'b1) : in_y;
			negx_s1 <= in_x[SW-1];
			negy_s1 <= in_y[SW-1];
		end
	end

	// s2: sum of squares, trigger compares
	logic              v_s2, rdy_s2;
	logic [2*SW-1:0]   sq_s2;
	logic [SIDE_W-1:0] side_s2;
	logic [2*SW-1:0]   sqx, sqy;
	logic [CW-1:0]     ax_c;
	logic              tdead_c, tsat_c;
	logic [CW-1:0]     tex_c;
	logic              sq_in_ready;

	assign sqx     = (2*SW)'(ax_s1) * (2*SW)'(ax_s1);
	assign sqy     = (2*SW)'(ay_s1) * (2*SW)'(ay_s1);
	assign ax_c    = CW'(ax_s1);
	assign tdead_c = ax_c <= CW'(trig_dz_q);
	assign tsat_c  = (full_scale_q <= tdz16) || (ax_c >= CW'(full_scale_q));
	assign tex_c   = ax_c - CW'(trig_dz_q);
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign rdy_s2  = !v_s2 || sq_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			sq_s2   <= sqx + sqy;
			side_s2 <= {op_s1, negx_s1, negy_s1, tdead_c, tsat_c, tex_c[SW-1:0],
				ax_s1, ay_s1};
		end
	end

	logic              len_valid;
	logic [SW-1:0]     len;
	logic [SIDE_W-1:0] len_side;
	logic              rdy_s3;

	gad_isqrt #(
		.W      (SW),
		.SIDE_W (SIDE_W)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (sq_in_ready),
		.in_n      (sq_s2),
		.in_side   (side_s2),
		.out_valid (len_valid),
		.out_ready (rdy_s3),
		.out_root  (len),
		.out_side  (len_side)
	);

	// s3: stick compares, excess and span
	logic          l_op, l_negx, l_negy, l_tdead, l_tsat;
	logic [SW-1:0] l_tex, l_ax, l_ay;
	logic [CW-1:0] len_c, lex_c;
	logic          sdead_c, ssat_c, stick;

	assign {l_op, l_negx, l_negy, l_tdead, l_tsat, l_tex, l_ax, l_ay} = len_side;
	assign len_c   = CW'(len);
	assign sdead_c = len_c < CW'(stick_dz_q);
	assign ssat_c  = (full_scale_q <= stick_dz_q) || (len_c >= CW'(full_scale_q));
	assign lex_c   = len_c - CW'(stick_dz_q);
	assign stick   = (op_t'(l_op) == OP_STICK);

	logic             v_s3, rdy_s4;
	op_t              op_s3;
	logic             negx_s3, negy_s3, dead_s3, zero_s3, sat_s3;
	logic [CFG_W-1:0] e_s3, span_s3;
	logic [SW-1:0]    len_s3, ax_s3, ay_s3, tex_s3;

	assign rdy_s3 = !v_s3 || rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= len_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && len_valid) begin
			op_s3   <= op_t'(l_op);
			negx_s3 <= l_negx;
			negy_s3 <= l_negy;
			dead_s3 <= stick ? sdead_c : l_tdead;
			zero_s3 <= stick ? (sdead_c || (len == '0)) : l_tdead;
			sat_s3  <= stick ? ssat_c : l_tsat;
			e_s3    <= lex_c[CFG_W-1:0];
			span_s3 <= stick ? (full_scale_q - stick_dz_q) : (full_scale_q - tdz16);
			len_s3  <= len;
			ax_s3   <= l_ax;
			ay_s3   <= l_ay;
			tex_s3  <= l_tex;
		end
	end

	// s4: numerators and divisor
	logic [MW-1:0] px, py, pd;
	logic [MW-1:0] nx_c, ny_c, d_c;

	assign px = MW'(ax_s3) * MW'(e_s3);
	assign py = MW'(ay_s3) * MW'(e_s3);
	assign pd = MW'(len_s3) * MW'(span_s3);

	always_comb begin
		priority if (zero_s3) begin
			nx_c = '0;
			ny_c = '0;
			d_c  = MW'(1);
		end else if (op_s3 == OP_TRIGGER) begin
			nx_c = sat_s3 ? MW'(1) : MW'(tex_s3);
			ny_c = '0;
			d_c  = sat_s3 ? MW'(1) : MW'(span_s3);
		end else if (sat_s3) begin
			nx_c = MW'(ax_s3);
			ny_c = MW'(ay_s3);
			d_c  = MW'(len_s3);
		end else begin
			nx_c = px;
			ny_c = py;
			d_c  = pd;
		end
	end

	logic          v_s4;
	logic [MW-1:0] nx_s4, ny_s4, d_s4;
	logic [2:0]    side_s4;
	logic          div_in_ready;

	assign rdy_s4 = !v_s4 || div_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			nx_s4   <= nx_c;
			ny_s4   <= ny_c;
			d_s4    <= d_c;
			side_s4 <= {negx_s3, negy_s3, dead_s3};
		end
	end

	logic          q_valid, rdy_s5;
	logic [QW-1:0] qx, qy;
	logic [2:0]    q_side;

	gad_div #(
		.W      (MW),
		.QW     (QW),
		.SIDE_W (3)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_in_ready),
		.in_nx     (nx_s4),
		.in_ny     (ny_s4),
		.in_d      (d_s4),
		.in_side   (side_s4),
		.out_valid (q_valid),
		.out_ready (rdy_s5),
		.out_qx    (qx),
		.out_qy    (qy),
		.out_side  (q_side)
	);

	// s5: sign and output word
	logic [PW-1:0]    magx, magy, sgx, sgy;
	logic             v_s5;
	logic [OUT_W-1:0] out_x_s5, out_y_s5;
	logic             dead_s5;

	assign magx   = PW'(qx);
	assign magy   = PW'(qy);
	assign sgx    = q_side[2] ? (PW'(0) - magx) : magx;
	assign sgy    = q_side[1] ? (PW'(0) - magy) : magy;
	assign rdy_s5 = !v_s5 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && q_valid) begin
			out_x_s5 <= sgx[OUT_W-1:0];
			out_y_s5 <= sgy[OUT_W-1:0];
			dead_s5  <= q_side[0];
		end
	end

	assign m_tvalid   = v_s5;
	assign m_tdata    = {out_y_s5, out_x_s5};
	assign m_tuser[0] = dead_s5;

endmodule

// ===== rtl/core/gad_isqrt.sv =====
module gad_isqrt #(
	parameter int W      = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2*W-1:0]    in_n,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [W-1:0]      out_root,
	output logic [SIDE_W-1:0] out_side
);

	localparam int NW = 2 * W;

	logic              v_s    [W];
	logic [NW-1:0]     rem_s  [W];
	logic [NW-1:0]     root_s [W];
	logic [SIDE_W-1:0] side_s [W];
	logic [W:0]        rdy;

	assign rdy[W]    = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = v_s[W-1];
	assign out_root  = root_s[W-1][W-1:0];
	assign out_side  = side_s[W-1];

	// one result bit per stage
	for (genvar k = 0; k < W; k++) begin : g_st
		localparam int SH = 2 * (W - 1 - k);
		logic              pv;
		logic [NW-1:0]     prem;
		logic [NW-1:0]     proot;
		logic [SIDE_W-1:0] pside;
		logic [NW-1:0]     bitc;
		logic [NW-1:0]     trial;
		logic [NW-1:0]     nrem;
		logic [NW-1:0]     nroot;

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = in_n;
			assign proot = '0;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign pside = side_s[k-1];
		end

		assign rdy[k] = !v_s[k] || rdy[k+1];
		assign bitc   = {{(NW-1){1'b0}}, 1'b1} << SH;
		assign trial  = proot + bitc;

		always_comb begin
			if (prem >= trial) begin
				nrem  = prem - trial;
				nroot = (proot >> 1) + bitc;
			end else begin
				nrem  = prem;
				nroot = proot >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && pv) begin
				rem_s[k]  <= nrem;
				root_s[k] <= nroot;
				side_s[k] <= pside;
			end
		end
	end

endmodule

// ===== rtl/core/gad_div.sv =====
module gad_div #(
	parameter int W      = 32,
	parameter int QW     = 15,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [W-1:0]      in_nx,
	input  logic [W-1:0]      in_ny,
	input  logic [W-1:0]      in_d,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [QW-1:0]     out_qx,
	output logic [QW-1:0]     out_qy,
	output logic [SIDE_W-1:0] out_side
);

	// numerators never exceed the divisor, so the top quotient bit needs
	// no shift and every remainder stays below the divisor
	logic              v_s    [QW];
	logic [W-1:0]      rx_s   [QW];
	logic [W-1:0]      ry_s   [QW];
	logic [W-1:0]      d_s    [QW];
	logic [QW-1:0]     qx_s   [QW];
	logic [QW-1:0]     qy_s   [QW];
	logic [SIDE_W-1:0] side_s [QW];
	logic [QW:0]       rdy;

	assign rdy[QW]   = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = v_s[QW-1];
	assign out_qx    = qx_s[QW-1];
	assign out_qy    = qy_s[QW-1];
	assign out_side  = side_s[QW-1];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic              pv;
		logic [W:0]        rinx;
		logic [W:0]        riny;
		logic [W:0]        dext;
		logic [W-1:0]      pd;
		logic [QW-1:0]     pqx;
		logic [QW-1:0]     pqy;
		logic [SIDE_W-1:0] pside;
		logic              bx;
		logic              by;
		logic [W:0]        subx;
		logic [W:0]        suby;

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign rinx  = {1'b0, in_nx};
			assign riny  = {1'b0, in_ny};
			assign pd    = in_d;
			assign pqx   = '0;
			assign pqy   = '0;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign rinx  = {rx_s[k-1], 1'b0};
			assign riny  = {ry_s[k-1], 1'b0};
			assign pd    = d_s[k-1];
			assign pqx   = qx_s[k-1];
			assign pqy   = qy_s[k-1];
			assign pside = side_s[k-1];
		end

		assign rdy[k] = !v_s[k] || rdy[k+1];
		assign dext   = {1'b0, pd};
		assign bx     = rinx >= dext;
		assign by     = riny >= dext;
		assign subx   = bx ? (rinx - dext) : rinx;
		assign suby   = by ? (riny - dext) : riny;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && pv) begin
				rx_s[k]   <= subx[W-1:0];
				ry_s[k]   <= suby[W-1:0];
				d_s[k]    <= pd;
				qx_s[k]   <= {pqx[QW-2:0], bx};
				qy_s[k]   <= {pqy[QW-2:0], by};
				side_s[k] <= pside;
			end
		end
	end

endmodule
